// ----- hw/rtl/cfd_pkg.sv -----
// Package for the CRC-16 frame deframer: shared constants, types and the
// CRC byte-update function. No dependencies.
package cfd_pkg;

    localparam int BYTE_W           = 8;
    localparam int LEN_W            = 16;
    localparam int CRC_W            = 16;
    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int MAX_RESULTS      = 64;
    localparam int RES_W            = $clog2(MAX_RESULTS + 1);

    localparam logic [CRC_W-1:0]  CRC_INIT     = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY     = 16'h1021;
    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hA5;

    // Scan sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_HDR,
        ST_LENH,
        ST_LENL,
        ST_BODY,
        ST_VERIFY,
        ST_EMPTY,
        ST_EMIT_RD,
        ST_EMIT,
        ST_DONE
    } state_t;

    // One result item as handed from the sequencer to the output register.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              empty;
    } result_t;

    // One byte of CRC-16/CCITT-FALSE, MSB first.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/cfd_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module cfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Read port; data holds until the next enabled read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/cfd_seq.sv -----
// Scan sequencer of the frame deframer: appends bytes to the circular byte
// buffer, walks it for frames, checks CRCs and emits payloads. Uses cfd_pkg.
module cfd_seq #(
    parameter int BUFFER_DEPTH = cfd_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [cfd_pkg::BYTE_W-1:0]      header_value,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [cfd_pkg::BYTE_W-1:0]      rx_byte,
    output logic                            mem_wr_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0] mem_wr_addr,
    output logic [cfd_pkg::BYTE_W-1:0]      mem_wr_data,
    output logic                            mem_rd_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0] mem_rd_addr,
    input  logic [cfd_pkg::BYTE_W-1:0]      mem_rd_data,
    input  logic                            out_free,
    output logic                            res_load,
    output cfd_pkg::result_t                res
);

    localparam int AW   = $clog2(BUFFER_DEPTH);
    localparam int CW   = $clog2(BUFFER_DEPTH + 1);
    localparam int EW   = ((cfd_pkg::LEN_W > CW) ? cfd_pkg::LEN_W : CW) + 2;
    localparam int RW   = cfd_pkg::RES_W;
    localparam int MAXL = BUFFER_DEPTH - 5;

    cfd_pkg::state_t           state_reg, state_next;
    logic [AW-1:0]             head_reg, head_next;
    logic [CW-1:0]             fill_reg, fill_next;
    logic [CW-1:0]             pos_reg, pos_next;
    logic [CW-1:0]             len_reg, len_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [CW-1:0]             off_reg, off_next;
    logic [CW-1:0]             k_reg, k_next;
    logic [RW-1:0]             results_reg, results_next;
    logic [cfd_pkg::BYTE_W-1:0] len_hi_reg, len_hi_next;
    logic [cfd_pkg::CRC_W-1:0]  crc_reg, crc_next;
    logic [cfd_pkg::CRC_W-1:0]  crc_upd;
    logic [CW-1:0]             rd_off;
    logic [cfd_pkg::LEN_W-1:0] len_full;
    logic [EW-1:0]             need;

    // Buffer offset to physical address, relative to the current head.
    function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [CW:0] s;
        s = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, off};
        if (s >= (CW + 1)'(BUFFER_DEPTH))
            s = s - (CW + 1)'(BUFFER_DEPTH);
        return s[AW-1:0];
    endfunction

    assign crc_upd     = cfd_pkg::crc_byte(crc_reg, mem_rd_data);
    assign len_full    = {len_hi_reg, mem_rd_data};
    assign need        = (len_reg == '0) ? EW'(1) : EW'(len_reg);
    assign in_stall    = (state_reg != cfd_pkg::ST_IDLE);
    assign mem_wr_data = rx_byte;
    assign mem_rd_addr = addr_of(head_reg, rd_off);

    // State and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= cfd_pkg::ST_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            pos_reg     <= '0;
            results_reg <= '0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            pos_reg     <= pos_next;
            results_reg <= results_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        cnt_reg    <= cnt_next;
        off_reg    <= off_next;
        k_reg      <= k_next;
        len_hi_reg <= len_hi_next;
        crc_reg    <= crc_next;
    end

    // Next state, memory requests and results.
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        off_next     = off_reg;
        k_next       = k_reg;
        results_next = results_reg;
        len_hi_next  = len_hi_reg;
        crc_next     = crc_reg;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = addr_of(head_reg, fill_reg);
        mem_rd_en    = 1'b0;
        rd_off       = pos_reg;
        res_load     = 1'b0;
        res          = '0;

        case (state_reg)
            cfd_pkg::ST_IDLE:
            begin
                if (in_valid) begin
                    mem_wr_en = 1'b1;
                    if (fill_reg == CW'(BUFFER_DEPTH)) begin
                        // Full buffer: the new byte replaces the oldest one.
                        mem_wr_addr = head_reg;
                        head_next   = addr_of(head_reg, CW'(1));
                    end else begin
                        fill_next = fill_reg + CW'(1);
                    end
                    pos_next     = '0;
                    results_next = '0;
                    state_next   = cfd_pkg::ST_CHECK;
                end
            end

            cfd_pkg::ST_CHECK:
            begin
                if (EW'(pos_reg) + EW'(4) > EW'(fill_reg)) begin
                    state_next = cfd_pkg::ST_DONE;
                end else begin
                    mem_rd_en  = 1'b1;
                    rd_off     = pos_reg;
                    state_next = cfd_pkg::ST_HDR;
                end
            end

            cfd_pkg::ST_HDR:
            begin
                if (mem_rd_data != header_value) begin
                    pos_next   = pos_reg + CW'(1);
                    state_next = cfd_pkg::ST_CHECK;
                end else begin
                    mem_rd_en  = 1'b1;
                    rd_off     = pos_reg + CW'(1);
                    crc_next   = cfd_pkg::CRC_INIT;
                    state_next = cfd_pkg::ST_LENH;
                end
            end

            cfd_pkg::ST_LENH:
            begin
                len_hi_next = mem_rd_data;
                crc_next    = crc_upd;
                mem_rd_en   = 1'b1;
                rd_off      = pos_reg + CW'(2);
                state_next  = cfd_pkg::ST_LENL;
            end

            cfd_pkg::ST_LENL:
            begin
                crc_next = crc_upd;
                if (EW'(len_full) > EW'(MAXL)) begin
                    // Length that can never fit: a false header.
                    pos_next   = pos_reg + CW'(1);
                    state_next = cfd_pkg::ST_CHECK;
                end else if (EW'(pos_reg) + EW'(len_full) + EW'(5) > EW'(fill_reg)) begin
                    // Frame not complete yet; wait for more bytes.
                    state_next = cfd_pkg::ST_DONE;
                end else begin
                    len_next   = CW'(len_full);
                    cnt_next   = CW'(len_full) + CW'(2);
                    mem_rd_en  = 1'b1;
                    rd_off     = pos_reg + CW'(3);
                    off_next   = pos_reg + CW'(4);
                    state_next = cfd_pkg::ST_BODY;
                end
            end

            cfd_pkg::ST_BODY:
            begin
                // CRC runs over payload and the received CRC; zero means a match.
                crc_next = crc_upd;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = cfd_pkg::ST_VERIFY;
                end else begin
                    mem_rd_en = 1'b1;
                    rd_off    = off_reg;
                    off_next  = off_reg + CW'(1);
                end
            end

            cfd_pkg::ST_VERIFY:
            begin
                if (crc_reg != '0) begin
                    pos_next   = pos_reg + CW'(1);
                    state_next = cfd_pkg::ST_CHECK;
                end else if (EW'(results_reg) + need > EW'(cfd_pkg::MAX_RESULTS)) begin
                    state_next = cfd_pkg::ST_DONE;
                end else if (len_reg == '0) begin
                    state_next = cfd_pkg::ST_EMPTY;
                end else begin
                    k_next     = '0;
                    state_next = cfd_pkg::ST_EMIT_RD;
                end
            end

            cfd_pkg::ST_EMPTY:
            begin
                if (out_free) begin
                    res_load     = 1'b1;
                    res.data     = '0;
                    res.last     = 1'b1;
                    res.empty    = 1'b1;
                    results_next = results_reg + RW'(1);
                    pos_next     = pos_reg + CW'(5);
                    state_next   = cfd_pkg::ST_CHECK;
                end
            end

            cfd_pkg::ST_EMIT_RD:
            begin
                mem_rd_en  = 1'b1;
                rd_off     = pos_reg + CW'(3) + k_reg;
                state_next = cfd_pkg::ST_EMIT;
            end

            cfd_pkg::ST_EMIT:
            begin
                if (out_free) begin
                    res_load     = 1'b1;
                    res.data     = mem_rd_data;
                    res.last     = (k_reg + CW'(1) == len_reg);
                    res.empty    = 1'b0;
                    results_next = results_reg + RW'(1);
                    k_next       = k_reg + CW'(1);
                    if (k_reg + CW'(1) == len_reg) begin
                        pos_next   = pos_reg + len_reg + CW'(5);
                        state_next = cfd_pkg::ST_CHECK;
                    end else begin
                        state_next = cfd_pkg::ST_EMIT_RD;
                    end
                end
            end

            cfd_pkg::ST_DONE:
            begin
                // Drop every byte the scan passed over.
                head_next  = addr_of(head_reg, pos_reg);
                fill_next  = fill_reg - pos_reg;
                state_next = cfd_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = cfd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/crc16_frame_deframer.sv -----
// Top level of the CRC-16 frame deframer: header register, output register,
// byte buffer RAM and scan sequencer. Uses cfd_pkg, cfd_ram and cfd_seq.
//
// Usage:
//   Received bytes enter on rx_byte with in_valid/in_stall; a transfer takes
//   place when in_valid is high and in_stall is low. Frames are a header
//   byte, a big-endian 16-bit length, the payload and a big-endian
//   CRC-16/CCITT-FALSE over length and payload. Each verified frame leaves
//   as one transfer per payload byte on payload_byte/packet_last/
//   packet_empty with out_valid/out_stall; an empty frame gives one transfer
//   with packet_empty set. The header byte is written through
//   cfg_valid/cfg_ready/cfg_data; the user must write it only while the
//   block is idle, which the block itself does not enforce.
//   After each accepted byte the sequencer rescans the buffer from its oldest
//   byte: it skips bytes that start no frame, checks the CRC of each
//   candidate frame, emits the payload of each verified one and then drops
//   the bytes it passed over; in_stall stays high until the scan is done.
//   Reset empties the buffer and sets the header to 0xA5; no clearing pass.
//   When the receiver stalls, the output register holds its result and the
//   scan waits on the next payload byte or empty marker until it frees up.
module crc16_frame_deframer #(
    parameter int BUFFER_DEPTH = cfd_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [cfd_pkg::BYTE_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [cfd_pkg::BYTE_W-1:0] rx_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [cfd_pkg::BYTE_W-1:0] payload_byte,
    output logic                       packet_last,
    output logic                       packet_empty
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [cfd_pkg::BYTE_W-1:0] header_reg;
    logic                       out_valid_reg;
    cfd_pkg::result_t           out_reg;
    logic                       out_free;
    logic                       res_load;
    cfd_pkg::result_t           res;
    logic                       mem_wr_en;
    logic [AW-1:0]              mem_wr_addr;
    logic [cfd_pkg::BYTE_W-1:0] mem_wr_data;
    logic                       mem_rd_en;
    logic [AW-1:0]              mem_rd_addr;
    logic [cfd_pkg::BYTE_W-1:0] mem_rd_data;

    // Header register, written by a configuration transfer.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            header_reg <= cfd_pkg::HEADER_RESET;
        else if (cfg_valid && cfg_ready)
            header_reg <= cfg_data;
    end

    // Output register; free when empty or when its result leaves this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            out_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = out_reg.data;
    assign packet_last  = out_reg.last;
    assign packet_empty = out_reg.empty;

    // Byte buffer.
    cfd_ram #(
        .WIDTH (cfd_pkg::BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Scan sequencer.
    cfd_seq #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .header_value (header_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data),
        .out_free     (out_free),
        .res_load     (res_load),
        .res          (res)
    );

endmodule
